// ===== rtl/core/pss_pkg.sv =====
package pss_pkg;

  // table size and per-tick result cap
  localparam int NUM_SLOTS   = 16;
  localparam int MAX_RESULTS = 16;

  // field widths
  localparam int SLOT_FW = 8;
  localparam int TIME_W  = 16;
  localparam int TASK_W  = 6;

  // derived widths
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  // item kinds
  localparam logic KIND_REG  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [SLOT_FW-1:0]  slot;
    logic [TIME_W-1:0]   period;
    logic [TIME_W-1:0]   start_delay;
    logic                active;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic               fired;
    logic [TASK_W-1:0]  task_index;
    logic               last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic do_reg;
    logic step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fire_rep;
    logic hold_valid;
    logic last_slot;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/pss_in_if.sv =====
interface pss_in_if import pss_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pss_out_if.sv =====
interface pss_out_if import pss_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pss_ctrl.sv =====
module pss_ctrl import pss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_kind,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REG,
    S_WALK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // stepping is blocked only when a held firing must move out first
  logic step_ok;
  assign step_ok = !(stat.fire_rep && stat.hold_valid) || stat.out_free;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_kind == KIND_TICK) ? S_WALK : S_REG;
        end
      end
      S_REG: begin
        if (stat.out_free) begin
          cmd.do_reg = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_WALK: begin
        if (step_ok) begin
          cmd.step = 1'b1;
          if (stat.last_slot) state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // at most one command per cycle
  assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("pss_ctrl: more than one datapath command");

  // a walk always ends in the final push state
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && stat.last_slot) |=> (state_r == S_DONE))
    else $error("pss_ctrl: walk did not close");

  // stepping never drops a held firing
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && stat.fire_rep && stat.hold_valid) |-> stat.out_free)
    else $error("pss_ctrl: held firing overwritten");

endmodule

// ===== rtl/core/pss_dp.sv =====
module pss_dp import pss_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_ready
);

  // slot table
  logic              used_r [NUM_SLOTS];
  logic              act_r  [NUM_SLOTS];
  logic [TIME_W-1:0] per_r  [NUM_SLOTS];
  logic [TIME_W-1:0] cd_r   [NUM_SLOTS];

  // walk and item state
  in_item_t          item_r;
  logic [SLOT_W-1:0] idx_r;
  logic              hold_valid_r;
  logic [SLOT_W-1:0] hold_idx_r;
  logic [CNT_W-1:0]  nrep_r;

  // output register
  logic              out_valid_r;
  out_item_t         out_r;

  // current slot view
  logic              live, fire, fire_rep;
  logic [TIME_W-1:0] cur_cd, cur_per, reload, cd_nxt;
  assign cur_cd   = cd_r[idx_r];
  assign cur_per  = per_r[idx_r];
  assign live     = used_r[idx_r] && act_r[idx_r];
  assign fire     = live && (cur_cd == '0);
  assign fire_rep = fire && (nrep_r < CNT_W'(MAX_RESULTS));
  assign reload   = (cur_per == '0) ? '0 : cur_per - TIME_W'(1);
  assign cd_nxt   = fire ? reload : cur_cd - TIME_W'(1);

  // register check, range tested before the table is read
  logic              in_range, bad;
  logic [SLOT_W-1:0] reg_idx;
  assign reg_idx  = item_r.slot[SLOT_W-1:0];
  assign in_range = item_r.slot < SLOT_FW'(NUM_SLOTS);
  assign bad      = !in_range || used_r[reg_idx];

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  // result push selection
  logic      push;
  out_item_t push_data;
  always_comb begin
    push      = 1'b0;
    push_data = '0;
    if (cmd.do_reg) begin
      push             = 1'b1;
      push_data.status = bad ? STATUS_ERR : STATUS_OK;
      push_data.last   = 1'b1;
    end else if (cmd.step && fire_rep && hold_valid_r) begin
      push                 = 1'b1;
      push_data.status     = STATUS_OK;
      push_data.fired      = 1'b1;
      push_data.task_index = TASK_W'(hold_idx_r);
    end else if (cmd.finish) begin
      push                 = 1'b1;
      push_data.status     = STATUS_OK;
      push_data.fired      = hold_valid_r;
      push_data.task_index = hold_valid_r ? TASK_W'(hold_idx_r) : '0;
      push_data.last       = 1'b1;
    end
  end

  // used flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) used_r[i] <= 1'b0;
    end else if (cmd.do_reg && !bad) begin
      used_r[reg_idx] <= 1'b1;
    end
  end

  // task fields and countdowns
  always_ff @(posedge clk) begin
    if (cmd.do_reg && !bad) begin
      act_r[reg_idx] <= item_r.active;
      per_r[reg_idx] <= item_r.period;
      cd_r[reg_idx]  <= item_r.start_delay;
    end else if (cmd.step && live) begin
      cd_r[idx_r] <= cd_nxt;
    end
  end

  // latched item and held firing index
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.step && fire_rep) hold_idx_r <= idx_r;
  end

  // walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      hold_valid_r <= 1'b0;
      nrep_r       <= '0;
    end else if (cmd.load) begin
      idx_r        <= '0;
      hold_valid_r <= 1'b0;
      nrep_r       <= '0;
    end else if (cmd.step) begin
      if (!stat.last_slot) idx_r <= idx_r + SLOT_W'(1);
      if (fire_rep) begin
        hold_valid_r <= 1'b1;
        nrep_r       <= nrep_r + CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) out_r <= push_data;
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign stat.fire_rep   = fire_rep;
  assign stat.hold_valid = hold_valid_r;
  assign stat.last_slot  = (idx_r == SLOT_W'(NUM_SLOTS - 1));
  assign stat.out_free   = out_free;

  // a push never lands on an undelivered result
  assert property (@(posedge clk) disable iff (!rst_n) push |-> out_free)
    else $error("pss_dp: result overwritten");

  // a held firing implies at least one counted report
  assert property (@(posedge clk) disable iff (!rst_n) hold_valid_r |-> (nrep_r != '0))
    else $error("pss_dp: hold without count");

  // firing results never carry an error status
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.fired) |-> (out_r.status == STATUS_OK))
    else $error("pss_dp: fired result with error");

endmodule

// ===== rtl/core/periodic_task_slot_scheduler.sv =====
// Periodic task slot scheduler
//
// in_ch carries items: kind 0 registers a task (slot, period, start_delay,
// active) into a free slot, kind 1 is one scheduler tick. out_ch returns
// results: a register item gives one result with status 0 (ok) or 1 (slot
// out of range or taken). A tick walks the slots from 0 upward and gives one
// result per task that fires, the final one marked by last; a tick with no
// firings gives one empty result with last set.
// Items are taken one at a time. A register item's result is written to the
// output register from the S_REG state, after which the next item can be
// taken. A tick walks the slots one per cycle while out_ch does not stall,
// as the walk reads the slot table through a single index, and then writes
// its last result from the S_DONE state before the next item is taken;
// a firing is held one step so that last can be set.
// in_ch.ready is high only between items.
// When out_ch stalls, the output register holds its result and the walk pauses
// at the next slot that fires while an earlier firing is held; a register or closing result waits.
// Reset (rst_n low, synchronous) empties every slot and clears the walk and
// output state; task fields need no clearing as they are read only once a
// slot is in use.
module periodic_task_slot_scheduler import pss_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  pss_in_if.sink   in_ch,
  pss_out_if.source out_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_kind  (in_ch.data.kind),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pss_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data),
    .out_ready (out_ch.ready)
  );

endmodule
